// ===== src/rrfp_pkg.sv =====
// Shared types and constants for the receive ring frame parser.
// No dependencies; imported by rrfp_hdr_check, rx_ring_frame_parser, rrfp_checker and the testbench.
package rrfp_pkg;

  // Result kinds carried on the output channel
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_ERROR     = 2'd2,
    KIND_NOT_READY = 2'd3
  } kind_e;

  // Parser phase
  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_e;

  // Header byte positions (little-endian status, then size)
  localparam logic [1:0] HdrStatusLo = 2'd0;
  localparam logic [1:0] HdrStatusHi = 2'd1;
  localparam logic [1:0] HdrSizeLo   = 2'd2;
  localparam logic [1:0] HdrSizeHi   = 2'd3;

  // Field widths fixed by the port list
  localparam int unsigned LenW    = 11;
  localparam int unsigned PtrW    = 16;
  localparam int unsigned RingOfsW = 13;

  // Ring geometry: a power of two, offset is the low bits of the pointer
  localparam int unsigned RingBytes = 8192;

  // Header checks
  localparam logic [15:0] SizeNotReady  = 16'hFFF0;
  localparam logic [5:0]  StatusOkBit   = 6'h01;
  localparam logic [5:0]  StatusBadBits = 6'h3E;
  localparam logic [15:0] MinFrame      = 16'd60;

  localparam logic [PtrW-1:0] CaprBias    = 16'd16;
  localparam logic [LenW-1:0] MaxLenReset = 11'd1514;

  // Header verdict and values derived from it
  typedef struct packed {
    logic        not_ready;
    logic        bad;
    logic [15:0] pkt_len;    // size minus CRC
    logic [15:0] body_last;  // index of the last byte after the header
    logic [15:0] ptr_next;   // read pointer after this frame
  } hdr_info_t;

endpackage

// ===== src/rx_ring_frame_parser.sv =====
// Receive ring frame parser top level: header parse, payload pass, done/error/not-ready.
// Depends on rrfp_pkg and rrfp_hdr_check.
//
//  channel  | signals                                   | dir | handshake
//  ---------+-------------------------------------------+-----+-------------
//  in       | ring_byte_i                               | in  | in_valid_i / in_ready_o
//  out      | kind_o data_o last_byte_o length_o        | out | out_valid_o / out_ready_i
//           | capr_o ring_offset_o                      |     |
//  cfg      | cfg_wdata_i (max_len)                     | in  | cfg_we_i, no wait
//
// One ring byte is taken per cycle; its result, if any, shows in the output
// register on the next cycle. Throughput is set by the single output register:
// a new byte is taken whenever that register is empty or is drained that cycle.
// A stall on out_ready_i stalls input only while a result is pending.
// Reset puts the parser in the header phase, pointer at 0, max_len at 1514.
module rx_ring_frame_parser #(
  parameter int unsigned MaxFrame = 1514
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rrfp_pkg::LenW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  ring_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rrfp_pkg::kind_e             kind_o,
  output logic [7:0]                  data_o,
  output logic                        last_byte_o,
  output logic [rrfp_pkg::LenW-1:0]   length_o,
  output logic [rrfp_pkg::PtrW-1:0]   capr_o,
  output logic [rrfp_pkg::RingOfsW-1:0] ring_offset_o
);
  import rrfp_pkg::*;

  // Body index holds up to the last byte of a padded maximum frame
  localparam int unsigned CntW = $clog2(MaxFrame + 7);
  localparam int unsigned CmpW = (CntW > LenW) ? CntW : LenW;
  localparam logic [PtrW-1:0] RingMask = PtrW'(RingBytes - 1);

  // Control state
  phase_e               phase_q, phase_d;
  logic [1:0]           hdr_cnt_q, hdr_cnt_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [PtrW-1:0]      rp_q, rp_d;
  logic [LenW-1:0]      max_len_q, max_len_d;
  logic                 out_valid_q, out_valid_d;

  // Frame payload state
  logic [5:0]           status_q, status_d;
  logic [7:0]           size_lo_q, size_lo_d;
  logic [CntW-1:0]      pkt_len_q, pkt_len_d;
  logic [CntW-1:0]      body_last_q, body_last_d;
  logic [PtrW-1:0]      ptr_pend_q, ptr_pend_d;

  // Output register
  kind_e                kind_q, kind_d;
  logic [7:0]           data_q, data_d;
  logic                 last_q, last_d;
  logic [LenW-1:0]      length_q, length_d;
  logic [PtrW-1:0]      capr_q, capr_d;
  logic [RingOfsW-1:0]  ofs_q, ofs_d;

  logic                 accept;
  hdr_info_t            info;
  logic [CmpW-1:0]      pkt_ext;
  logic [CmpW-1:0]      max_ext;
  logic [CmpW-1:0]      pkt_eff;
  logic [CmpW-1:0]      idx_ext;
  logic                 res_valid;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  rrfp_hdr_check #(
    .MaxFrame (MaxFrame)
  ) u_hdr_check (
    .status_i  (status_q),
    .size_lo_i (size_lo_q),
    .size_hi_i (ring_byte_i),
    .rd_ptr_i  (rp_q),
    .info_o    (info)
  );

  // Delivered length: frame payload clipped to the current buffer size
  assign pkt_ext = CmpW'(pkt_len_q);
  assign max_ext = CmpW'(max_len_q);
  assign pkt_eff = (pkt_ext > max_ext) ? max_ext : pkt_ext;
  assign idx_ext = CmpW'(cnt_q);

  // Next state and result
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    cnt_d       = cnt_q;
    rp_d        = rp_q;
    max_len_d   = cfg_we_i ? cfg_wdata_i : max_len_q;
    status_d    = status_q;
    size_lo_d   = size_lo_q;
    pkt_len_d   = pkt_len_q;
    body_last_d = body_last_q;
    ptr_pend_d  = ptr_pend_q;
    res_valid   = 1'b0;
    kind_d      = KIND_DATA;
    data_d      = '0;
    last_d      = 1'b0;
    length_d    = '0;
    capr_d      = '0;
    ofs_d       = '0;

    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          case (hdr_cnt_q)
            HdrStatusLo: status_d  = ring_byte_i[5:0];
            HdrSizeLo:   size_lo_d = ring_byte_i;
            default: ;
          endcase
          if (hdr_cnt_q != HdrSizeHi) begin
            hdr_cnt_d = hdr_cnt_q + 2'd1;
          end else begin
            hdr_cnt_d = HdrStatusLo;
            if (info.not_ready) begin
              res_valid = 1'b1;
              kind_d    = KIND_NOT_READY;
            end else if (info.bad) begin
              rp_d      = '0;
              res_valid = 1'b1;
              kind_d    = KIND_ERROR;
              capr_d    = '0 - CaprBias;
            end else begin
              phase_d     = PH_BODY;
              cnt_d       = '0;
              pkt_len_d   = info.pkt_len[CntW-1:0];
              body_last_d = info.body_last[CntW-1:0];
              ptr_pend_d  = info.ptr_next;
            end
          end
        end
        PH_BODY: begin
          if (cnt_q == body_last_q) begin
            // Last consumed byte: report and move the pointer
            phase_d   = PH_HEADER;
            cnt_d     = '0;
            rp_d      = ptr_pend_q;
            res_valid = 1'b1;
            kind_d    = KIND_DONE;
            length_d  = LenW'(pkt_eff);
            capr_d    = ptr_pend_q - CaprBias;
            ofs_d     = RingOfsW'(ptr_pend_q & RingMask);
          end else begin
            cnt_d = cnt_q + 1'b1;
            if (idx_ext < pkt_eff) begin
              res_valid = 1'b1;
              kind_d    = KIND_DATA;
              data_d    = ring_byte_i;
              last_d    = ((idx_ext + 1'b1) == pkt_eff);
            end
          end
        end
        default: phase_d = PH_HEADER;
      endcase
    end

    // Output register: load on accept, drain on downstream take
    if (accept) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= HdrStatusLo;
      cnt_q       <= '0;
      rp_q        <= '0;
      max_len_q   <= MaxLenReset;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      cnt_q       <= cnt_d;
      rp_q        <= rp_d;
      max_len_q   <= max_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    size_lo_q   <= size_lo_d;
    pkt_len_q   <= pkt_len_d;
    body_last_q <= body_last_d;
    ptr_pend_q  <= ptr_pend_d;
    if (accept) begin
      kind_q   <= kind_d;
      data_q   <= data_d;
      last_q   <= last_d;
      length_q <= length_d;
      capr_q   <= capr_d;
      ofs_q    <= ofs_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign data_o        = data_q;
  assign last_byte_o   = last_q;
  assign length_o      = length_q;
  assign capr_o        = capr_q;
  assign ring_offset_o = ofs_q;

  // Body index never runs past the frame's last byte
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (cnt_q <= body_last_q))
    else $error("body index past last byte");

  // An error result always rewinds the pointer to the ring start
  a_err_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_ERROR) |->
      (rp_q == '0 && capr_q == ('0 - CaprBias) && ofs_q == '0))
    else $error("error result without pointer rewind");

  // A done result reports the pointer the parser now holds
  a_done_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_DONE) |->
      (capr_q == (rp_q - CaprBias) && ofs_q == RingOfsW'(rp_q & RingMask)))
    else $error("done pointer mismatch");

  // Last-byte flag only on payload items
  a_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> (kind_q == KIND_DATA))
    else $error("last_byte on non-payload item");

  // A pending result is held while the receiver stalls and no input is accepted
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!accept && !out_ready_i && out_valid_q) |=> out_valid_q)
    else $error("pending result dropped");

endmodule

// ===== src/rrfp_hdr_check.sv =====
// Header classification for the receive ring frame parser.
// Depends on rrfp_pkg; works on the last header byte as it arrives.
module rrfp_hdr_check #(
  parameter int unsigned MaxFrame = 1514
) (
  input  logic [5:0]             status_i,
  input  logic [7:0]             size_lo_i,
  input  logic [7:0]             size_hi_i,
  input  logic [rrfp_pkg::PtrW-1:0] rd_ptr_i,
  output rrfp_pkg::hdr_info_t    info_o
);
  import rrfp_pkg::*;

  localparam logic [15:0] MaxSize = 16'(MaxFrame + 4);

  logic [15:0] size;
  logic [15:0] size_rnd;
  logic [15:0] ptr_sum;

  assign size = {size_hi_i, size_lo_i};

  // Size plus the 4-byte header plus 3; clearing the low two bits rounds up to a 4-byte boundary
  assign size_rnd = size + 16'd7;
  assign ptr_sum  = rd_ptr_i + size_rnd;

  always_comb begin
    info_o.not_ready = (size == SizeNotReady);
    info_o.bad       = ((status_i & StatusOkBit) == '0) ||
                       ((status_i & StatusBadBits) != '0) ||
                       (size < MinFrame) || (size > MaxSize);
    info_o.pkt_len   = size - 16'd4;
    info_o.body_last = {size_rnd[15:2], 2'b00} - 16'd5;
    info_o.ptr_next  = {ptr_sum[15:2], 2'b00};
  end

endmodule

// ===== sim/rrfp_checker.sv =====
// Result checker for rx_ring_frame_parser: tracks config writes and accepted ring bytes,
// predicts each result item and compares it with what the output channel delivers.
// Depends on rrfp_pkg for result kinds, widths and header constants.
module rrfp_checker
  import rrfp_pkg::*;
#(
  parameter int unsigned MaxFrame = 1514
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LenW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [7:0]          ring_byte_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  kind_e               kind_i,
  input  logic [7:0]          data_i,
  input  logic                last_byte_i,
  input  logic [LenW-1:0]     length_i,
  input  logic [PtrW-1:0]     capr_i,
  input  logic [RingOfsW-1:0] ring_offset_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_o,
  output int unsigned         results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           data;
    logic                 last_b;
    logic [LenW-1:0]      length;
    logic [PtrW-1:0]      capr;
    logic [RingOfsW-1:0]  ofs;
  } rx_result_t;

  // Shadow of the parser state
  rx_result_t      parser_results_q[$];
  phase_e          ph;
  logic [10:0]     pos;
  logic [15:0]     status_w;
  logic [15:0]     size_w;
  logic [PtrW-1:0] rd_ptr;
  logic [LenW-1:0] buf_len;

  function automatic rx_result_t make_result(kind_e k, logic [7:0] d, logic l,
                                             logic [LenW-1:0] n, logic [PtrW-1:0] c,
                                             logic [RingOfsW-1:0] o);
    rx_result_t r;
    r.kind   = k;
    r.data   = d;
    r.last_b = l;
    r.length = n;
    r.capr   = c;
    r.ofs    = o;
    return r;
  endfunction

  // Advance the shadow parser by one ring byte and queue any result it causes
  task automatic parse_byte(input logic [7:0] b);
    int unsigned sz;
    int unsigned pkt;
    int unsigned body_total;
    int unsigned idx;
    if (ph != PH_BODY) begin
      case (pos[1:0])
        HdrStatusLo: status_w = {8'h00, b};
        HdrStatusHi: status_w[15:8] = b;
        HdrSizeLo:   size_w = {8'h00, b};
        default:     size_w[15:8] = b;
      endcase
      if (pos[1:0] != HdrSizeHi) begin
        pos = {9'd0, pos[1:0] + 2'd1};
        return;
      end
      pos = '0;
      if (size_w == SizeNotReady) begin
        parser_results_q.push_back(make_result(KIND_NOT_READY, '0, 1'b0, '0, '0, '0));
      end else if ((status_w[5:0] & StatusOkBit) == '0 ||
                   (status_w[5:0] & StatusBadBits) != '0 ||
                   size_w < MinFrame || int'(size_w) > int'(MaxFrame) + 4) begin
        rd_ptr = '0;
        parser_results_q.push_back(make_result(KIND_ERROR, '0, 1'b0, '0,
                                               rd_ptr - CaprBias, '0));
      end else begin
        ph = PH_BODY;
      end
      return;
    end

    // body: payload, then dropped tail, CRC and padding
    sz = 32'(size_w);
    pkt = sz - 4;
    body_total = ((sz + 7) / 4) * 4 - 4;
    idx = 32'(pos);
    if (pkt > 32'(buf_len)) pkt = 32'(buf_len);
    if (idx + 1 >= body_total) begin
      rd_ptr = (rd_ptr + size_w + 16'd7) & 16'hFFFC;
      ph = PH_HEADER;
      pos = '0;
      parser_results_q.push_back(make_result(KIND_DONE, '0, 1'b0, pkt[LenW-1:0],
                                             rd_ptr - CaprBias, rd_ptr[RingOfsW-1:0]));
      return;
    end
    pos = pos + 11'd1;
    if (idx < pkt) begin
      parser_results_q.push_back(make_result(KIND_DATA, b, idx + 1 == pkt, '0, '0, '0));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rx_result_t got;
    rx_result_t want;
    if (!rst_ni) begin
      parser_results_q.delete();
      ph = PH_HEADER;
      pos = '0;
      status_w = '0;
      size_w = '0;
      rd_ptr = '0;
      buf_len = MaxLenReset;
      mismatch_count_o = 0;
      results_seen_o = 0;
      pending_o = 0;
    end else begin
      // compare a delivered result item with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        results_seen_o++;
        got = make_result(kind_i, data_i, last_byte_i, length_i, capr_i, ring_offset_i);
        if (parser_results_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("[%0t] unexpected result: kind=%0d data=%02h last=%0d len=%0d %s",
                     $realtime, got.kind, got.data, got.last_b, got.length,
                     $sformatf("capr=%04h ofs=%04h", got.capr, got.ofs));
        end else begin
          want = parser_results_q.pop_front();
          if (got !== want) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("[%0t] mismatch: exp kind=%0d data=%02h last=%0d len=%0d %s",
                       $realtime, want.kind, want.data, want.last_b, want.length,
                       $sformatf("capr=%04h ofs=%04h", want.capr, want.ofs));
              $display("           got kind=%0d data=%02h last=%0d len=%0d %s",
                       got.kind, got.data, got.last_b, got.length,
                       $sformatf("capr=%04h ofs=%04h", got.capr, got.ofs));
            end
          end
        end
      end
      // register write, then the accepted input item
      if (cfg_we_i) buf_len = cfg_wdata_i;
      if (in_valid_i && in_ready_i) parse_byte(ring_byte_i);
      pending_o = parser_results_q.size();
    end
  end

endmodule

// ===== sim/tb_rx_ring_frame_parser.sv =====
// Testbench top for rx_ring_frame_parser: clock, reset, ring byte stimulus and verdict.
// Depends on rrfp_pkg, rx_ring_frame_parser and rrfp_checker.
module tb_rx_ring_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import rrfp_pkg::*;

  localparam int unsigned MaxFrame   = 1514;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainLimit = 50_000;
  localparam int unsigned TailCycles = 4;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [LenW-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic [7:0]          ring_byte_i = '0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  kind_e               kind_o;
  logic [7:0]          data_o;
  logic                last_byte_o;
  logic [LenW-1:0]     length_o;
  logic [PtrW-1:0]     capr_o;
  logic [RingOfsW-1:0] ring_offset_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned frames_sent = 0;
  int unsigned cfg_writes  = 0;
  int unsigned burst_left  = 0;
  bit          bursty      = 1'b1;

  rx_ring_frame_parser #(.MaxFrame(MaxFrame)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .ring_byte_i,
    .out_valid_o, .out_ready_i, .kind_o, .data_o, .last_byte_o,
    .length_o, .capr_o, .ring_offset_o
  );

  rrfp_checker #(.MaxFrame(MaxFrame)) result_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .ring_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i, .kind_i(kind_o), .data_i(data_o),
    .last_byte_i(last_byte_o), .length_i(length_o), .capr_i(capr_o),
    .ring_offset_i(ring_offset_o),
    .mismatch_count_o(mismatches), .pending_o(pending), .results_seen_o(results_seen)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_rx_ring_frame_parser: errors");
      $finish;
    end
  end

  // receiver backpressure: one of four random ready patterns, chosen anew periodically
  always @(posedge clk_i) begin
    int unsigned rx_mode;
    if (cycle_count % 50 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 2) == 0);
      default: out_ready_i <= cycle_count[2];
    endcase
  end

  // one ring byte; sender gaps fall between bursts
  task automatic send_byte(input logic [7:0] b);
    if (bursty) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid_i  <= 1'b1;
    ring_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_header(input logic [15:0] status, input logic [15:0] sz);
    send_byte(status[7:0]);
    send_byte(status[15:8]);
    send_byte(sz[7:0]);
    send_byte(sz[15:8]);
  endtask

  // well-formed frame with random upper status bits and random body
  task automatic send_frame(input logic [15:0] sz);
    logic [15:0] status;
    logic [7:0]  rb;
    int unsigned body;
    status = 16'($urandom);
    status[5:0] = StatusOkBit;
    body = ((int'(sz) + 7) / 4) * 4 - 4;
    send_header(status, sz);
    repeat (body) begin
      rb = 8'($urandom);
      send_byte(rb);
    end
    frames_sent++;
  endtask

  // header that fails one check, or is not ready, or is plain noise
  task automatic send_broken_header();
    logic [15:0] st;
    logic [15:0] sz;
    st = 16'($urandom);
    st[5:0] = StatusOkBit;
    sz = 16'($urandom_range(60, MaxFrame + 4));
    case ($urandom_range(0, 5))
      0: st[0] = 1'b0;
      1: st[$urandom_range(1, 5)] = 1'b1;
      2: sz = 16'($urandom_range(0, 59));
      3: sz = 16'($urandom_range(MaxFrame + 5, 16'hFFFF));
      4: sz = SizeNotReady;
      default: begin
        st = 16'($urandom);
        sz = 16'($urandom);
      end
    endcase
    send_header(st, sz);
  endtask

  // write max_len once the parser has drained
  task automatic set_max_len(input logic [LenW-1:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  // one max_len setting: mostly short frames, some longer, some broken headers
  task automatic run_phase(input logic [LenW-1:0] len, input logic [15:0] first_size,
                           input int unsigned quota);
    int unsigned start;
    int unsigned r;
    set_max_len(len);
    bursty = ($urandom_range(0, 3) != 0);
    burst_left = 0;
    start = items_sent;
    send_frame(first_size);
    while (items_sent - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 60) send_frame(16'($urandom_range(60, 140)));
      else if (r < 75) send_frame(16'($urandom_range(141, 220)));
      else send_broken_header();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed headers at the reset max_len: each check, not ready, all-ones noise
    send_header(16'h0000, 16'd60);
    send_header(16'h0003, 16'd60);
    send_header(16'h0021, 16'd60);
    send_header(16'h0001, 16'd59);
    send_header(16'h0001, 16'd1519);
    send_header(16'h0001, SizeNotReady);
    send_header(16'hFFFF, 16'hFFFF);

    // settings sweep, extremes included
    run_phase(MaxLenReset, 16'd200, 90);
    run_phase(11'd0, 16'd60, 90);
    run_phase(11'd1, 16'd61, 90);
    run_phase(11'd2047, 16'd63, 90);
    run_phase(11'd56, 16'd60, 90);
    run_phase(11'd57, 16'd62, 90);
    run_phase(LenW'($urandom_range(2, 200)), 16'd60, 90);
    run_phase(LenW'($urandom_range(2, 1514)), 16'd60, 90);

    // drain, then let the output register settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    for (int unsigned n = 0; n < DrainLimit && pending != 0; n++) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d ring bytes (%0d good frames) over %0d max_len writes;",
             items_sent, frames_sent, cfg_writes);
    $display("%0d results checked.", results_seen);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_rx_ring_frame_parser: clean");
    end else begin
      $display("tb_rx_ring_frame_parser: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rrfp_pkg.sv
src/rrfp_hdr_check.sv
src/rx_ring_frame_parser.sv
sim/rrfp_checker.sv
sim/tb_rx_ring_frame_parser.sv
